// ===== src/dbu_pkg.sv =====
package dbu_pkg;

    // Width of the read length counter. The header count is masked to this many bits.
    localparam int READ_LEN_BITS = 16;

    // Depth of the queue between the parser and the base emitter.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Values of the pack_mode register.
    localparam logic MODE_2BIT = 1'b0;
    localparam logic MODE_4BIT = 1'b1;

    // Base codes.
    localparam logic [3:0] CODE_A = 4'd0;
    localparam logic [3:0] CODE_G = 4'd1;
    localparam logic [3:0] CODE_C = 4'd2;
    localparam logic [3:0] CODE_T = 4'd3;
    localparam logic [3:0] CODE_N = 4'd4;

    // ASCII characters that are sent out.
    localparam logic [6:0] CHAR_A     = 7'h41;
    localparam logic [6:0] CHAR_G     = 7'h47;
    localparam logic [6:0] CHAR_C     = 7'h43;
    localparam logic [6:0] CHAR_T     = 7'h54;
    localparam logic [6:0] CHAR_N     = 7'h4E;
    localparam logic [6:0] CHAR_EMPTY = 7'h00;

    // One unit of work for the base emitter: either an empty-read marker or
    // one data byte with the number of bases it carries, less one.
    typedef struct packed {
        logic       empty;
        logic       mode;
        logic       last;
        logic [1:0] nb;
        logic [7:0] data;
    } dbu_entry_t;

    // Any code above N decodes to N; the caller flags it as bad.
    function automatic logic [6:0] code_to_char(input logic [3:0] code);
        logic [6:0] ch;
        unique case (code)
            CODE_A:  ch = CHAR_A;
            CODE_G:  ch = CHAR_G;
            CODE_C:  ch = CHAR_C;
            CODE_T:  ch = CHAR_T;
            default: ch = CHAR_N;
        endcase
        return ch;
    endfunction

endpackage

// ===== src/dbu_front.sv =====
module dbu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         byte_in,
    input  logic               pack_mode,
    output logic               push,
    output dbu_pkg::dbu_entry_t push_entry
);
    import dbu_pkg::*;

    typedef enum logic [1:0] {
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [7:0]                 length_low_reg, length_low_next;
    logic [READ_LEN_BITS-1:0]   remaining_reg, remaining_next;

    logic [15:0]                full_len;
    logic [READ_LEN_BITS-1:0]   len;
    logic [2:0]                 per_byte;
    logic                       ends_here;
    logic [2:0]                 n_bases;

    assign full_len  = {byte_in, length_low_reg};
    assign len       = full_len[READ_LEN_BITS-1:0];
    assign per_byte  = (pack_mode == MODE_4BIT) ? 3'd2 : 3'd4;
    assign ends_here = remaining_reg <= READ_LEN_BITS'(per_byte);
    assign n_bases   = ends_here ? remaining_reg[2:0] : per_byte;

    always_comb
    begin
        phase_next      = phase_reg;
        length_low_next = length_low_reg;
        remaining_next  = remaining_reg;
        push            = 1'b0;
        push_entry      = '0;
        push_entry.mode = pack_mode;
        push_entry.data = byte_in;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN_HI:
                begin
                    remaining_next = len;
                    if (len == '0)
                    begin
                        push             = 1'b1;
                        push_entry.empty = 1'b1;
                        push_entry.last  = 1'b1;
                        phase_next       = PH_LEN_LO;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    push            = 1'b1;
                    push_entry.nb   = 2'(n_bases - 3'd1);
                    push_entry.last = ends_here;
                    remaining_next  = remaining_reg - READ_LEN_BITS'(n_bases);
                    if (ends_here)
                    begin
                        phase_next = PH_LEN_LO;
                    end
                end
                default:
                begin
                    length_low_next = byte_in;
                    phase_next      = PH_LEN_HI;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEN_LO;
            length_low_reg <= '0;
            remaining_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            length_low_reg <= length_low_next;
            remaining_reg  <= remaining_next;
        end
    end

endmodule

// ===== src/dbu_fifo.sv =====
module dbu_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dbu_pkg::dbu_entry_t push_entry,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output dbu_pkg::dbu_entry_t head
);
    import dbu_pkg::*;

    dbu_entry_t           mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full      = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/dbu_back.sv =====
module dbu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  dbu_pkg::dbu_entry_t head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [6:0]          base_char,
    output logic                last_in_read,
    output logic                bad_code,
    output logic                empty_read
);
    import dbu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] base_char_reg;
    logic       last_reg, bad_reg, empty_reg;

    logic       slot_free;
    logic       emit;
    logic       entry_done;
    logic [3:0] code;
    logic [6:0] ch;
    logic       bad;

    assign slot_free  = !out_valid_reg || !out_stall;
    assign emit       = head_valid && slot_free;
    assign entry_done = idx_reg == head.nb;
    assign pop        = emit && entry_done;

    always_comb
    begin
        if (head.mode == MODE_4BIT)
        begin
            code = 4'(head.data >> {idx_reg[0], 2'b00});
        end
        else
        begin
            code = {2'b00, 2'(head.data >> {idx_reg, 1'b0})};
        end
        bad = code > CODE_N;
        ch  = head.empty ? CHAR_EMPTY : code_to_char(code);
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (slot_free)
        begin
            out_valid_next = head_valid;
        end
        if (emit)
        begin
            idx_next = entry_done ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            base_char_reg <= ch;
            last_reg      <= head.last && entry_done;
            bad_reg       <= bad && !head.empty;
            empty_reg     <= head.empty;
        end
    end

    assign out_valid    = out_valid_reg;
    assign base_char    = base_char_reg;
    assign last_in_read = last_reg;
    assign bad_code     = bad_reg;
    assign empty_read   = empty_reg;

endmodule

// ===== src/dna_base_unpacker.sv =====
// A data byte's first base is written into the queue and then into the emitter's output
// register, from which it is presented at the output; out_stall can hold it in between.
// Throughput: one base per cycle while out_stall is low, limited by the single output
// register of the emitter, so a full 2-bit data byte drains as four bases and a 4-bit one as two.
// Header bytes are parsed at one per cycle while the four-entry queue has room.
// Reset (rst_n low, asynchronous) clears the parser to expect a length low byte,
// empties the queue and the output register, and sets pack_mode to 2-bit mode.
module dna_base_unpacker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] base_char,
    output logic       last_in_read,
    output logic       bad_code,
    output logic       empty_read
);
    import dbu_pkg::*;

    // The block is split into a parser and an emitter with a short queue in
    // between. The parser walks the length header and the data bytes of each
    // read and, for every data byte, works out how many bases it carries and
    // whether the read ends in it. The emitter then sends those bases out one
    // per cycle unless out_stall holds it; the input side keeps taking bytes while the queue has room.

    logic       pack_mode_reg;
    logic       accept;
    logic       push;
    dbu_entry_t push_entry;
    logic       fifo_full;
    logic       fifo_not_empty;
    dbu_entry_t fifo_head;
    logic       pop;

    // The mode register is sampled per data byte, so each byte is decoded
    // with the mode that holds when it arrives.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_mode_reg <= MODE_2BIT;
        end
        else if (cfg_wr_en)
        begin
            pack_mode_reg <= cfg_wr_data;
        end
    end

    // Stall whenever the queue is full. Header bytes are held as well, which
    // keeps the stall a plain decode of the queue count register.
    assign in_stall = fifo_full;
    assign accept   = in_valid && !in_stall;

    dbu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .byte_in    (byte_in),
        .pack_mode  (pack_mode_reg),
        .push       (push),
        .push_entry (push_entry)
    );

    dbu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (fifo_full),
        .not_empty  (fifo_not_empty),
        .head       (fifo_head)
    );

    // The emitter steps through the bases of the queue head and pops the
    // entry with its last base. A zero-length read is a single marker item.
    dbu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (fifo_not_empty),
        .head         (fifo_head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .base_char    (base_char),
        .last_in_read (last_in_read),
        .bad_code     (bad_code),
        .empty_read   (empty_read)
    );

endmodule

// ===== src/dbu_checker.sv =====
module dbu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [6:0] base_char,
    input logic       last_in_read,
    input logic       bad_code,
    input logic       empty_read
);
    import dbu_pkg::*;

    // A stalled output item holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(base_char)
            && $stable(last_in_read) && $stable(bad_code) && $stable(empty_read))
        else $error("output item changed while stalled");

    // An empty-read marker is a zero character that also closes the read.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_read |-> last_in_read && base_char == CHAR_EMPTY && !bad_code)
        else $error("malformed empty-read marker");

    // A bad code always comes out as N.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_code |-> base_char == CHAR_N && !empty_read)
        else $error("bad code not shown as N");

    // Every real base is one of the five letters.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_read |-> base_char == CHAR_A || base_char == CHAR_G
            || base_char == CHAR_C || base_char == CHAR_T || base_char == CHAR_N)
        else $error("unexpected base character");

endmodule

bind dna_base_unpacker dbu_checker u_dbu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .base_char    (base_char),
    .last_in_read (last_in_read),
    .bad_code     (bad_code),
    .empty_read   (empty_read)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import dbu_pkg::*;

    // The run is stopped here if it has not ended on its own.
    localparam int RUN_LIMIT = 600000;
    // The random part stops once about this many stream bytes have been sent.
    localparam int RANDOM_ITEMS = 215;
    // Cycles allowed after the last expected base for the block to finish
    // work that produces no output, such as a header byte it is still parsing.
    localparam int SETTLE_CYCLES = 8;
    // A read of 257 bases takes this many data bytes in 2-bit mode.
    localparam int BIG_READ_BYTES = 65;
    localparam logic [31:0] LEN_MASK = (32'd1 << READ_LEN_BITS) - 32'd1;

    // Where the stream parser stands: waiting for the count low byte, the
    // count high byte, or inside the data bytes of a read.
    typedef enum logic [1:0] {
        WANT_LEN_LO,
        WANT_LEN_HI,
        WANT_DATA
    } parse_phase_t;

    // One emitted base as it leaves the block.
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       bad;
        logic       empty;
    } base_out_t;

    // Tracks the stream the way the block should parse it and keeps the bases
    // that are still owed, oldest first.
    class base_tracker;
        logic         mode;
        parse_phase_t phase;
        logic [7:0]   len_lo;
        logic [15:0]  left;
        base_out_t    pending_bases[$];
        int           mismatches;

        function new();
            mode       = MODE_2BIT;
            phase      = WANT_LEN_LO;
            len_lo     = 8'h00;
            left       = 16'h0000;
            mismatches = 0;
        endfunction

        function void set_mode(logic m);
            mode = m;
        endfunction

        function int outstanding();
            return pending_bases.size();
        endfunction

        // Called for every byte the block accepts.
        function void take_byte(logic [7:0] b);
            logic [31:0] full;
            logic [7:0]  shifted;
            logic [3:0]  code;
            int          per_byte;
            int          bits;
            base_out_t   r;
            case (phase)
                WANT_LEN_HI:
                begin
                    full = {16'h0000, b, len_lo} & LEN_MASK;
                    left = full[15:0];
                    if (left == 16'h0000)
                    begin
                        // A zero count gives a single empty marker.
                        r.ch    = CHAR_EMPTY;
                        r.last  = 1'b1;
                        r.bad   = 1'b0;
                        r.empty = 1'b1;
                        pending_bases.push_back(r);
                        phase = WANT_LEN_LO;
                    end
                    else
                        phase = WANT_DATA;
                end
                WANT_DATA:
                begin
                    per_byte = (mode == MODE_4BIT) ? 2 : 4;
                    bits     = (mode == MODE_4BIT) ? 4 : 2;
                    // Codes come from the low bits up; padding after the last
                    // base of the read is dropped.
                    for (int i = 0; i < per_byte && left != 16'h0000; i++)
                    begin
                        shifted = b >> (bits * i);
                        code = (mode == MODE_4BIT) ? shifted[3:0] : {2'b00, shifted[1:0]};
                        case (code)
                            CODE_A:  r.ch = CHAR_A;
                            CODE_G:  r.ch = CHAR_G;
                            CODE_C:  r.ch = CHAR_C;
                            CODE_T:  r.ch = CHAR_T;
                            default: r.ch = CHAR_N;
                        endcase
                        r.bad   = (code > CODE_N);
                        left    = left - 16'd1;
                        r.last  = (left == 16'h0000);
                        r.empty = 1'b0;
                        pending_bases.push_back(r);
                    end
                    if (left == 16'h0000)
                        phase = WANT_LEN_LO;
                end
                default:
                begin
                    len_lo = b;
                    phase  = WANT_LEN_HI;
                end
            endcase
        endfunction

        // Called for every base the block hands over.
        function void match_base(base_out_t got);
            base_out_t want;
            if (pending_bases.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected base, expected none, ", $time,
                         "got char %h last %b bad %b empty %b",
                         got.ch, got.last, got.bad, got.empty);
                return;
            end
            want = pending_bases.pop_front();
            if (got != want)
            begin
                mismatches++;
                $display("%0t: base mismatch, ", $time,
                         "expected char %h last %b bad %b empty %b, ",
                         want.ch, want.last, want.bad, want.empty,
                         "got char %h last %b bad %b empty %b",
                         got.ch, got.last, got.bad, got.empty);
            end
        endfunction
    endclass

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] byte_in     = 8'h00;
    logic       out_stall   = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [6:0] base_char;
    logic       last_in_read;
    logic       bad_code;
    logic       empty_read;

    base_tracker sb = new();

    // Largest idle gap each side may draw per item; changed from phase to phase.
    int in_gap_max  = 12;
    int out_gap_max = 12;
    // When set, the receiver holds off for this many cycles once.
    int hold_len    = 0;
    int cycle_count = 0;
    int random_items;

    // Stream generator state. It follows the mode that is in force, so a read
    // that spans a mode change still gets the right number of data bytes.
    logic         cur_mode  = MODE_2BIT;
    parse_phase_t gen_phase = WANT_LEN_LO;
    logic [15:0]  gen_left  = 16'h0000;

    dna_base_unpacker uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_in      (byte_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .base_char    (base_char),
        .last_in_read (last_in_read),
        .bad_code     (bad_code),
        .empty_read   (empty_read)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog. A correct run ends far below this limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bases still expected",
                     cycle_count, sb.outstanding());
            $display("tb: FAIL");
            $finish;
        end
    end

    // Every base taken from the block is checked against the oldest one owed.
    // Sampling at the edge sees the values that held before it.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.match_base({base_char, last_in_read, bad_code, empty_read});
    end

    // Receiver. Before each base it stalls for a random number of cycles, or
    // for a long stretch when the stimulus asks for one, then takes the base.
    initial
    begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                hold     = hold_len;
                hold_len = 0;
            end
            else
                hold = $urandom_range(0, out_gap_max);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // Offers one byte after a random gap and returns at the edge that takes
    // it. Valid is left high so that a following byte with no gap goes out
    // back to back.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.take_byte(b);
    endtask

    // Stops offering and waits until every owed base has come out, then a
    // few more cycles for header bytes that are still being parsed.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called while the block is idle.
    task automatic write_mode(input logic m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_mode(m);
        cur_mode = m;
    endtask

    function automatic int pick_gap_max();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 12;
        endcase
    endfunction

    // Next byte of an endless stream of well formed reads with random data.
    // Counts are mostly short; a few are zero, a few span more than one
    // header byte.
    function automatic logic [7:0] next_stream_byte();
        int         pick;
        int         per_byte;
        logic [7:0] b;
        case (gen_phase)
            WANT_LEN_LO:
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    gen_left = 16'd0;
                else if (pick < 80)
                    gen_left = 16'($urandom_range(1, 12));
                else if (pick < 95)
                    gen_left = 16'($urandom_range(13, 64));
                else
                    gen_left = 16'($urandom_range(256, 300));
                b = gen_left[7:0];
                gen_phase = WANT_LEN_HI;
            end
            WANT_LEN_HI:
            begin
                b = gen_left[15:8];
                gen_phase = (gen_left == 16'd0) ? WANT_LEN_LO : WANT_DATA;
            end
            default:
            begin
                b = 8'($urandom_range(0, 255));
                per_byte = (cur_mode == MODE_4BIT) ? 2 : 4;
                if (gen_left > per_byte)
                    gen_left = gen_left - 16'(per_byte);
                else
                begin
                    gen_left  = 16'd0;
                    gen_phase = WANT_LEN_LO;
                end
            end
        endcase
        return b;
    endfunction

    initial
    begin
        logic [7:0] two_bit_reads[$];
        logic [7:0] four_bit_reads[$];
        int         phase_bytes;
        int         phase_idx;
        logic       m;

        // 2-bit mode: an empty read, a single base with three padding codes,
        // one full byte of all four codes, and a read that spills into a
        // second byte.
        two_bit_reads = {8'h00, 8'h00,
                         8'h01, 8'h00, 8'hFF,
                         8'h04, 8'h00, 8'hE4,
                         8'h05, 8'h00, 8'h1B, 8'h00};
        // 4-bit mode: the five good codes, the lowest and highest bad codes,
        // and a read whose tail is sent after a switch back to 2-bit mode.
        four_bit_reads = {8'h02, 8'h00, 8'h10,
                          8'h03, 8'h00, 8'h32, 8'h04,
                          8'h02, 8'h00, 8'hF5,
                          8'h06, 8'h00, 8'h21};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(MODE_2BIT);
        foreach (two_bit_reads[i])
            send_byte(two_bit_reads[i]);
        settle();

        write_mode(MODE_4BIT);
        foreach (four_bit_reads[i])
            send_byte(four_bit_reads[i]);
        // The last read is halfway through; its remaining four bases come
        // from one 2-bit byte.
        settle();
        write_mode(MODE_2BIT);
        send_byte(8'hE4);
        settle();

        // One read whose count needs both header bytes, streamed with no
        // idling on either side.
        in_gap_max  = 0;
        out_gap_max = 0;
        send_byte(8'h01);
        send_byte(8'h01);
        repeat (BIG_READ_BYTES)
            send_byte(8'($urandom_range(0, 255)));
        settle();

        // Random phases. A phase ends at an arbitrary byte, so mode changes
        // land inside headers and inside reads as well as between reads.
        phase_idx    = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            m = (phase_idx < 2) ? phase_idx[0] : 1'($urandom_range(0, 1));
            write_mode(m);
            if (phase_idx == 3)
            begin
                // The receiver stops for a long while as the sender keeps
                // going, which fills the queue and stalls the input.
                in_gap_max  = 0;
                out_gap_max = 12;
                hold_len    = 80;
            end
            else
            begin
                in_gap_max  = pick_gap_max();
                out_gap_max = pick_gap_max();
            end
            phase_bytes = $urandom_range(15, 45);
            repeat (phase_bytes)
                send_byte(next_stream_byte());
            random_items += phase_bytes;
            settle();
            phase_idx++;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
